// ----- hw/rtl/ptw_pkg.sv -----
// types, constants and microcode program of the page table walker
package ptw_pkg;

   // field and entry widths
   localparam int MODE_W   = 2;
   localparam int ROOT_W   = 6;
   localparam int VPN_W    = 36;
   localparam int PAGE_W   = 40;
   localparam int FLAGS_W  = 12;
   localparam int STATUS_W = 2;
   localparam int ENTRY_W  = 64;
   localparam int CSR_W    = 7;
   localparam int IDX_W    = 9;
   localparam int ENTRIES  = 512;
   localparam int STEP_W   = 5;

   // entry flag bit positions
   localparam int BIT_PRESENT = 0;
   localparam int BIT_USER    = 2;

   // first table frame after reset
   localparam logic [CSR_W-1:0] FIRST_FRAME_RESET = 7'd1;

   // request modes
   localparam logic [MODE_W-1:0] MODE_LOOKUP = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAP    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNMAP  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RSVD   = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_DONE       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOT_MAPPED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_NO_FRAME   = 2'd2;

   // datapath actions, one per control word
   typedef enum logic [3:0] {
      OP_NONE       = 4'd0,
      OP_INIT_CLR   = 4'd1,
      OP_IDLE       = 4'd2,
      OP_ISSUE      = 4'd3,
      OP_DESCEND    = 4'd4,
      OP_NOT_MAPPED = 4'd5,
      OP_NO_FRAME   = 4'd6,
      OP_ALLOC      = 4'd7,
      OP_ZERO       = 4'd8,
      OP_LINK       = 4'd9,
      OP_FOUND      = 4'd10,
      OP_CLEAR_LEAF = 4'd11,
      OP_MAP_LEAF   = 4'd12,
      OP_RESP       = 4'd13
   } op_type;

   // branch conditions
   typedef enum logic [3:0] {
      C_ALWAYS      = 4'd0,
      C_NO_REQ      = 4'd1,
      C_SKIP        = 4'd2,
      C_INIT_MORE   = 4'd3,
      C_LEAF_LVL    = 4'd4,
      C_PRESENT     = 4'd5,
      C_NOT_PRESENT = 4'd6,
      C_FRAME_BAD   = 4'd7,
      C_NOT_MAP     = 4'd8,
      C_MAP         = 4'd9,
      C_UNMAP       = 4'd10,
      C_EXHAUSTED   = 4'd11,
      C_SWEEP_MORE  = 4'd12,
      C_OUT_BUSY    = 4'd13
   } cond_sel_type;

   typedef logic [STEP_W-1:0] step_type;

   // program step addresses
   localparam step_type S_INIT      = 5'd0;
   localparam step_type S_IDLE      = 5'd1;
   localparam step_type S_CHECK     = 5'd2;
   localparam step_type S_ISSUE     = 5'd3;
   localparam step_type S_TABLE     = 5'd4;
   localparam step_type S_DESCEND   = 5'd5;
   localparam step_type S_MISS      = 5'd6;
   localparam step_type S_ALLOC_CHK = 5'd7;
   localparam step_type S_ALLOC     = 5'd8;
   localparam step_type S_ZERO      = 5'd9;
   localparam step_type S_LINK      = 5'd10;
   localparam step_type S_LEAF      = 5'd11;
   localparam step_type S_LOOK      = 5'd12;
   localparam step_type S_LEAF_DONE = 5'd13;
   localparam step_type S_CLR_LEAF  = 5'd14;
   localparam step_type S_MAP_LEAF  = 5'd15;
   localparam step_type S_NOT_MAP   = 5'd16;
   localparam step_type S_NO_FRAME  = 5'd17;
   localparam step_type S_RESP      = 5'd18;

   // control word: action, condition, target when true, target when false
   typedef struct packed {
      op_type       op;
      cond_sel_type cond;
      step_type     br;
      step_type     nx;
   } uword_type;

   // status flags from the datapath to the sequencer
   typedef struct packed {
      logic no_req;
      logic skip;
      logic init_more;
      logic leaf_lvl;
      logic present;
      logic frame_bad;
      logic is_map;
      logic is_unmap;
      logic exhausted;
      logic sweep_more;
      logic out_busy;
   } cond_type;

   // microcode program
   function automatic uword_type ucode_rom(input step_type s);
      uword_type w;
      case (s)
         S_INIT:      w = '{OP_INIT_CLR,   C_INIT_MORE,   S_INIT,      S_IDLE};
         S_IDLE:      w = '{OP_IDLE,       C_NO_REQ,      S_IDLE,      S_CHECK};
         S_CHECK:     w = '{OP_NONE,       C_SKIP,        S_NOT_MAP,   S_ISSUE};
         S_ISSUE:     w = '{OP_ISSUE,      C_LEAF_LVL,    S_LEAF,      S_TABLE};
         S_TABLE:     w = '{OP_NONE,       C_PRESENT,     S_DESCEND,   S_MISS};
         S_DESCEND:   w = '{OP_DESCEND,    C_FRAME_BAD,   S_NOT_MAP,   S_ISSUE};
         S_MISS:      w = '{OP_NONE,       C_NOT_MAP,     S_NOT_MAP,   S_ALLOC_CHK};
         S_ALLOC_CHK: w = '{OP_NONE,       C_EXHAUSTED,   S_NO_FRAME,  S_ALLOC};
         S_ALLOC:     w = '{OP_ALLOC,      C_ALWAYS,      S_ZERO,      S_ZERO};
         S_ZERO:      w = '{OP_ZERO,       C_SWEEP_MORE,  S_ZERO,      S_LINK};
         S_LINK:      w = '{OP_LINK,       C_ALWAYS,      S_ISSUE,     S_ISSUE};
         S_LEAF:      w = '{OP_NONE,       C_MAP,         S_MAP_LEAF,  S_LOOK};
         S_LOOK:      w = '{OP_FOUND,      C_NOT_PRESENT, S_NOT_MAP,   S_LEAF_DONE};
         S_LEAF_DONE: w = '{OP_NONE,       C_UNMAP,       S_CLR_LEAF,  S_RESP};
         S_CLR_LEAF:  w = '{OP_CLEAR_LEAF, C_ALWAYS,      S_RESP,      S_RESP};
         S_MAP_LEAF:  w = '{OP_MAP_LEAF,   C_ALWAYS,      S_RESP,      S_RESP};
         S_NOT_MAP:   w = '{OP_NOT_MAPPED, C_ALWAYS,      S_RESP,      S_RESP};
         S_NO_FRAME:  w = '{OP_NO_FRAME,   C_ALWAYS,      S_RESP,      S_RESP};
         S_RESP:      w = '{OP_RESP,       C_OUT_BUSY,    S_RESP,      S_IDLE};
         default:     w = '{OP_NONE,       C_ALWAYS,      S_IDLE,      S_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ----- hw/rtl/ptw_if.sv -----
// request and response channel interfaces of the page table walker
interface ptw_req_if import ptw_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [MODE_W-1:0]   mode;
   logic [ROOT_W-1:0]   root_frame;
   logic [VPN_W-1:0]    virt_page;
   logic [PAGE_W-1:0]   target_page;
   logic [FLAGS_W-1:0]  leaf_attr;
   logic                no_execute;

   modport source (
      output valid, mode, root_frame, virt_page, target_page, leaf_attr, no_execute,
      input  ready
   );
   modport sink (
      input  valid, mode, root_frame, virt_page, target_page, leaf_attr, no_execute,
      output ready
   );
endinterface

interface ptw_rsp_if import ptw_pkg::*; ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [PAGE_W-1:0]   found_page;

   modport source (
      output valid, status, found_page,
      input  ready
   );
   modport sink (
      input  valid, status, found_page,
      output ready
   );
endinterface

// ----- hw/rtl/ptw_sequencer.sv -----
// microcode sequencer: step counter, program rom and branch select
module ptw_sequencer import ptw_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cond_type cond,
   output op_type   op
);

   step_type  upc_ff;
   step_type  upc_in;
   uword_type word;
   logic      taken;

   // fetch the control word of the current step
   assign word = ucode_rom(upc_ff);
   assign op   = word.op;

   // branch condition select
   always_comb begin
      case (word.cond)
         C_ALWAYS:      taken = 1'b1;
         C_NO_REQ:      taken = cond.no_req;
         C_SKIP:        taken = cond.skip;
         C_INIT_MORE:   taken = cond.init_more;
         C_LEAF_LVL:    taken = cond.leaf_lvl;
         C_PRESENT:     taken = cond.present;
         C_NOT_PRESENT: taken = !cond.present;
         C_FRAME_BAD:   taken = cond.frame_bad;
         C_NOT_MAP:     taken = !cond.is_map;
         C_MAP:         taken = cond.is_map;
         C_UNMAP:       taken = cond.is_unmap;
         C_EXHAUSTED:   taken = cond.exhausted;
         C_SWEEP_MORE:  taken = cond.sweep_more;
         C_OUT_BUSY:    taken = cond.out_busy;
         default:       taken = 1'b0;
      endcase
   end

   assign upc_in = taken ? word.br : word.nx;

   // step counter, reset starts the store clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= S_INIT;
      end else begin
         upc_ff <= upc_in;
      end
   end

endmodule

// ----- hw/rtl/ptw_datapath.sv -----
// walker datapath: request registers, table store, allocator, result register
module ptw_datapath import ptw_pkg::*; #(
   parameter int TABLE_FRAMES = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  op_type           op,
   output cond_type         cond,
   ptw_req_if.sink          req_chan,
   ptw_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   localparam int FRAME_W = $clog2(TABLE_FRAMES);
   localparam int ADDR_W  = FRAME_W + IDX_W;
   localparam int DEPTH   = TABLE_FRAMES * ENTRIES;
   localparam int CNT_W   = ($clog2(TABLE_FRAMES + 1) > CSR_W) ?
                            $clog2(TABLE_FRAMES + 1) : CSR_W;

   // latched request
   logic [MODE_W-1:0]   mode_ff;
   logic [VPN_W-1:0]    vpn_ff;
   logic [PAGE_W-1:0]   target_ff;
   logic [FLAGS_W-1:0]  flags_ff;
   logic                nx_ff;
   logic                skip_ff;

   // walk state
   logic [FRAME_W-1:0]  frame_ff;
   logic [1:0]          lvl_ff;
   logic [FRAME_W-1:0]  nf_ff;
   logic [ADDR_W-1:0]   clr_ff;
   logic [CNT_W-1:0]    next_ff;
   logic [ENTRY_W-1:0]  rd_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [PAGE_W-1:0]   found_ff;

   // result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [PAGE_W-1:0]   rsp_found_ff;

   logic [ENTRY_W-1:0]  mem [DEPTH];

   logic [IDX_W-1:0]    idx;
   logic [ADDR_W-1:0]   tbl_addr;
   logic [PAGE_W-1:0]   entry_frame;
   logic [ENTRY_W-1:0]  link_entry;
   logic [ENTRY_W-1:0]  leaf_entry;
   logic                we;
   logic [ADDR_W-1:0]   wa;
   logic [ENTRY_W-1:0]  wd;
   logic                accept;
   logic                out_busy;

   assign accept   = req_chan.valid && req_chan.ready;
   assign out_busy = rsp_valid_ff && !rsp_chan.ready;

   // level index, top level first
   always_comb begin
      case (lvl_ff)
         2'd0:    idx = vpn_ff[35:27];
         2'd1:    idx = vpn_ff[26:18];
         2'd2:    idx = vpn_ff[17:9];
         default: idx = vpn_ff[8:0];
      endcase
   end

   assign tbl_addr    = {frame_ff, idx};
   assign entry_frame = rd_ff[51:12];
   assign link_entry  = {12'b0, PAGE_W'(nf_ff), 9'b0, flags_ff[BIT_USER], 2'b11};
   assign leaf_entry  = {nx_ff, 11'b0, target_ff, flags_ff};

   // store write port select
   always_comb begin
      we = 1'b0;
      wa = tbl_addr;
      wd = '0;
      case (op)
         OP_INIT_CLR: begin
            we = 1'b1;
            wa = clr_ff;
         end
         OP_ZERO: begin
            we = 1'b1;
            wa = {nf_ff, clr_ff[IDX_W-1:0]};
         end
         OP_LINK: begin
            we = 1'b1;
            wd = link_entry;
         end
         OP_MAP_LEAF: begin
            we = 1'b1;
            wd = leaf_entry;
         end
         OP_CLEAR_LEAF: begin
            we = 1'b1;
         end
         default: ;
      endcase
   end

   // table store, one write and one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (op == OP_ISSUE) begin
         rd_ff <= mem[tbl_addr];
      end
   end

   // sweep counter, allocator and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         next_ff      <= CNT_W'(FIRST_FRAME_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (op == OP_INIT_CLR || op == OP_ZERO) begin
            clr_ff <= clr_ff + ADDR_W'(1);
         end else if (op == OP_ALLOC) begin
            clr_ff <= '0;
         end
         if (csr_we) begin
            next_ff <= CNT_W'(csr_wdata);
         end else if (op == OP_ALLOC) begin
            next_ff <= next_ff + CNT_W'(1);
         end
         if (op == OP_RESP && !out_busy) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request capture and walk registers
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_chan.mode;
         vpn_ff    <= req_chan.virt_page;
         target_ff <= req_chan.target_page;
         flags_ff  <= req_chan.leaf_attr;
         nx_ff     <= req_chan.no_execute;
         skip_ff   <= (req_chan.mode == MODE_RSVD) ||
                      (PAGE_W'(req_chan.root_frame) >= PAGE_W'(TABLE_FRAMES));
         frame_ff  <= FRAME_W'(req_chan.root_frame);
         lvl_ff    <= 2'd0;
         status_ff <= ST_DONE;
         found_ff  <= '0;
      end
      case (op)
         OP_DESCEND: begin
            frame_ff <= entry_frame[FRAME_W-1:0];
            lvl_ff   <= lvl_ff + 2'd1;
         end
         OP_ALLOC: begin
            nf_ff <= next_ff[FRAME_W-1:0];
         end
         OP_LINK: begin
            frame_ff <= nf_ff;
            lvl_ff   <= lvl_ff + 2'd1;
         end
         OP_FOUND: begin
            found_ff <= entry_frame;
         end
         OP_NOT_MAPPED: begin
            status_ff <= ST_NOT_MAPPED;
            found_ff  <= '0;
         end
         OP_NO_FRAME: begin
            status_ff <= ST_NO_FRAME;
            found_ff  <= '0;
         end
         default: ;
      endcase
      if (op == OP_RESP && !out_busy) begin
         rsp_status_ff <= status_ff;
         rsp_found_ff  <= found_ff;
      end
   end

   // flags for the sequencer
   assign cond.no_req     = !req_chan.valid;
   assign cond.skip       = skip_ff;
   assign cond.init_more  = clr_ff != ADDR_W'(DEPTH - 1);
   assign cond.leaf_lvl   = lvl_ff == 2'd3;
   assign cond.present    = rd_ff[BIT_PRESENT];
   assign cond.frame_bad  = entry_frame >= PAGE_W'(TABLE_FRAMES);
   assign cond.is_map     = mode_ff == MODE_MAP;
   assign cond.is_unmap   = mode_ff == MODE_UNMAP;
   assign cond.exhausted  = next_ff >= CNT_W'(TABLE_FRAMES);
   assign cond.sweep_more = clr_ff[IDX_W-1:0] != '1;
   assign cond.out_busy   = out_busy;

   // channel outputs
   assign req_chan.ready      = op == OP_IDLE;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.found_page = rsp_found_ff;

endmodule

// ----- hw/rtl/four_level_page_table_walker.sv -----
// top level of the four level page table walker
//
// req_chan takes one lookup, map or unmap request per beat; rsp_chan returns
// one beat with status and found page for every request, in order.
// csr_we with csr_wdata sets the first table frame and reloads the frame
// allocator; write it only while no request is in flight.
// A microcoded sequencer runs the walk: each level runs the steps read issue,
// entry check and descend through the single read port of the table store.
// Each table that map has to create spends almost all of its time in the
// one-entry-per-cycle zeroing of the new 512-entry frame.
// One request is in flight at a time; the next beat is accepted as soon as
// the result sits in the output register, even while rsp_chan stalls.
// A stalled result holds its beat; the walk then waits in its response step.
// After reset the block clears the whole store, one entry a cycle,
// TABLE_FRAMES * 512 entries (32768 by default), with req_chan.ready low.
module four_level_page_table_walker import ptw_pkg::*; #(
   parameter int TABLE_FRAMES = 64
) (
   input  logic             clock,
   input  logic             reset,
   ptw_req_if.sink          req_chan,
   ptw_rsp_if.source        rsp_chan,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata
);

   op_type   op;
   cond_type cond;

   // program sequencer
   ptw_sequencer u_seq (
      .clock (clock),
      .reset (reset),
      .cond  (cond),
      .op    (op)
   );

   // datapath and table store
   ptw_datapath #(
      .TABLE_FRAMES (TABLE_FRAMES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .op        (op),
      .cond      (cond),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // one request in flight: no second beat right after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("request accepted back to back");

   // a result beat appears only from the response step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(op == OP_RESP))
      else $error("result valid outside response step");

   // failed requests report no page
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status != ST_DONE) |-> rsp_chan.found_page == '0)
      else $error("page reported with failing status");

endmodule
